// ===== rtl/rlm_pkg.sv =====
// Shared constants, mode codes and controller/datapath command types for the RMS level meter.
package rlm_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_WIDTH  = 32;
  localparam int SUM_WIDTH    = 63;
  localparam int SQ_WIDTH     = 2 * SAMPLE_WIDTH;
  localparam int LEVEL_WIDTH  = 15;
  localparam int ROOT_WIDTH   = 64;

  localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX = LEVEL_WIDTH'(32767);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // One quotient bit per divider step, two radicand bits per root step.
  localparam int DIV_STEPS  = SUM_WIDTH;
  localparam int ROOT_STEPS = ROOT_WIDTH / 2;
  localparam int CNT_WIDTH  = $clog2(DIV_STEPS);

  localparam logic [CNT_WIDTH-1:0] DIV_LAST  = CNT_WIDTH'(DIV_STEPS - 1);
  localparam logic [CNT_WIDTH-1:0] ROOT_LAST = CNT_WIDTH'(ROOT_STEPS - 1);

  typedef enum logic [1:0] {
    MODE_ACC  = 2'd0,
    MODE_CLR  = 2'd1,
    MODE_READ = 2'd2
  } mode_t;

  typedef struct packed {
    logic acc;
    logic clr;
    logic rd;
    logic div_init;
    logic div_step;
    logic root_init;
    logic root_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
  } stat_t;

endpackage

// ===== rtl/rlm_in_if.sv =====
// Command channel: mode and PCM sample with valid/ready handshake.
interface rlm_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          mode;
  logic signed [rlm_pkg::SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink   (input valid, input mode, input sample, output ready);
endinterface

// ===== rtl/rlm_out_if.sv =====
// Result channel: RMS level and empty flag with valid/ready handshake.
interface rlm_out_if;
  logic                             valid;
  logic                             ready;
  logic [rlm_pkg::LEVEL_WIDTH-1:0]  rms_level;
  logic                             no_samples;

  modport source (output valid, output rms_level, output no_samples, input ready);
  modport sink   (input valid, input rms_level, input no_samples, output ready);
endinterface

// ===== rtl/rlm_ctrl.sv =====
// Controller state machine: handshakes and sequencing of divide and root steps.
module rlm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_mode,
  input  logic                out_ready,
  input  rlm_pkg::stat_t      stat,
  output rlm_pkg::cmd_t       cmd,
  output logic                in_ready,
  output logic                out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETTLE,
    S_DIV,
    S_RINIT,
    S_ROOT,
    S_EMIT
  } state_t;

  state_t                         state;
  logic [rlm_pkg::CNT_WIDTH-1:0]  cnt;
  logic                           accept;
  logic                           emit_go;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit_go  = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    cmd           = '0;
    cmd.acc       = accept && (in_mode == rlm_pkg::MODE_ACC);
    cmd.clr       = accept && (in_mode == rlm_pkg::MODE_CLR);
    cmd.rd        = accept && (in_mode == rlm_pkg::MODE_READ);
    cmd.div_init  = (state == S_SETTLE);
    cmd.div_step  = (state == S_DIV);
    cmd.root_init = (state == S_RINIT);
    cmd.root_step = (state == S_ROOT);
    cmd.load_out  = emit_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result replaces the one taken at this edge
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.rd) begin
            // empty meter skips the arithmetic
            state <= stat.count_zero ? S_EMIT : S_SETTLE;
          end
        end
        S_SETTLE: begin
          // last pending square lands in the sum before the divide loads it
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == rlm_pkg::DIV_LAST) begin
            state <= S_RINIT;
          end
        end
        S_RINIT: begin
          cnt   <= '0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          cnt <= cnt + 1'b1;
          if (cnt == rlm_pkg::ROOT_LAST) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/rlm_datapath.sv =====
// Datapath: square-and-accumulate, restoring divider, digit-by-digit root, result register.
module rlm_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rlm_pkg::cmd_t                         cmd,
  input  logic signed [rlm_pkg::SAMPLE_WIDTH-1:0] sample,
  output rlm_pkg::stat_t                        stat,
  output logic [rlm_pkg::LEVEL_WIDTH-1:0]       rms_level,
  output logic                                  no_samples
);

  logic [rlm_pkg::SUM_WIDTH-1:0]    sum_of_squares;
  logic [rlm_pkg::COUNT_WIDTH-1:0]  sample_count;
  logic [rlm_pkg::SQ_WIDTH-1:0]     sq;
  logic                             sq_valid;
  logic [rlm_pkg::SAMPLE_WIDTH-1:0] mag;
  logic                             empty;

  // divider: dividend shifts out on top while quotient bits shift in below
  logic [rlm_pkg::SUM_WIDTH-1:0]    dq;
  logic [rlm_pkg::COUNT_WIDTH-1:0]  rem;
  logic [rlm_pkg::COUNT_WIDTH:0]    trial;
  logic                             q_bit;

  logic [rlm_pkg::ROOT_WIDTH-1:0]   rrem;
  logic [rlm_pkg::ROOT_WIDTH-1:0]   root;
  logic [rlm_pkg::ROOT_WIDTH-1:0]   rbit;
  logic [rlm_pkg::ROOT_WIDTH-1:0]   rtry;
  logic                             r_fit;

  assign stat.count_zero = (sample_count == '0);

  // -32768 wraps to 0x8000, which is its magnitude as unsigned
  assign mag = sample[rlm_pkg::SAMPLE_WIDTH-1] ? (~sample + 1'b1) : sample;

  assign trial = {rem, dq[rlm_pkg::SUM_WIDTH-1]};
  assign q_bit = (trial >= {1'b0, sample_count});

  assign rtry  = root + rbit;
  assign r_fit = (rrem >= rtry);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_of_squares <= '0;
      sample_count   <= '0;
      sq_valid       <= 1'b0;
    end else begin
      sq_valid <= 1'b0;
      if (cmd.clr) begin
        sum_of_squares <= '0;
        sample_count   <= '0;
      end else begin
        if (sq_valid) begin
          sum_of_squares <= sum_of_squares + rlm_pkg::SUM_WIDTH'(sq);
        end
        // drop samples once the count is full
        if (cmd.acc && (sample_count != rlm_pkg::COUNT_MAX)) begin
          sample_count <= sample_count + 1'b1;
          sq_valid     <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      sq <= mag * mag;
    end
    if (cmd.rd) begin
      empty <= stat.count_zero;
    end
    if (cmd.div_init) begin
      dq  <= sum_of_squares;
      rem <= '0;
    end else if (cmd.div_step) begin
      dq <= {dq[rlm_pkg::SUM_WIDTH-2:0], q_bit};
      if (q_bit) begin
        rem <= rlm_pkg::COUNT_WIDTH'(trial - {1'b0, sample_count});
      end else begin
        rem <= trial[rlm_pkg::COUNT_WIDTH-1:0];
      end
    end
    if (cmd.root_init) begin
      rrem <= rlm_pkg::ROOT_WIDTH'(dq);
      root <= '0;
      rbit <= {2'b01, {(rlm_pkg::ROOT_WIDTH-2){1'b0}}};
    end else if (cmd.root_step) begin
      if (r_fit) begin
        rrem <= rrem - rtry;
        root <= (root >> 1) + rbit;
      end else begin
        root <= root >> 1;
      end
      rbit <= rbit >> 2;
    end
    if (cmd.load_out) begin
      no_samples <= empty;
      if (empty) begin
        rms_level <= '0;
      end else if (root > rlm_pkg::ROOT_WIDTH'(rlm_pkg::LEVEL_MAX)) begin
        rms_level <= rlm_pkg::LEVEL_MAX;
      end else begin
        rms_level <= root[rlm_pkg::LEVEL_WIDTH-1:0];
      end
    end
  end

endmodule

// ===== rtl/rms_level_meter.sv =====
// RMS level meter top level: controller, datapath and channel wiring.
// Accumulate and clear beats keep the input ready: a new beat is accepted every cycle
// outside a read. A read runs settle, 63 divider steps, root setup, 32 root steps and
// output load before its result beat (only the load with no samples); input stalls meanwhile.
// The result register lets new beats in while a result waits to be taken.
// Synchronous active-high reset clears the sum, the count and all handshake state.
module rms_level_meter (
  input  logic       clk,
  input  logic       rst,
  rlm_in_if.sink     in,
  rlm_out_if.source  out
);

  rlm_pkg::cmd_t  cmd;
  rlm_pkg::stat_t stat;

  rlm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in.valid),
    .in_mode   (in.mode),
    .out_ready (out.ready),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in.ready),
    .out_valid (out.valid)
  );

  rlm_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sample     (in.sample),
    .stat       (stat),
    .rms_level  (out.rms_level),
    .no_samples (out.no_samples)
  );

  a_read_stalls: assert property (@(posedge clk) disable iff (rst)
    in.valid && in.ready && (in.mode == rlm_pkg::MODE_READ) |=> !in.ready)
    else $error("input still ready after a read beat");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    in.valid && in.ready && (in.mode == rlm_pkg::MODE_CLR) |=> stat.count_zero)
    else $error("count not zero after a clear beat");

  a_empty_level: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.no_samples |-> (out.rms_level == '0))
    else $error("nonzero level reported with no samples");

endmodule
